FILE: rtl/core/att_pkg.sv
package att_pkg;

  localparam int unsigned ScreenCols = 80;
  localparam int unsigned ScreenRows = 25;
  localparam int unsigned NumCells   = ScreenCols * ScreenRows;
  localparam int unsigned RowW       = 5;
  localparam int unsigned ColW       = 7;
  localparam int unsigned AddrW      = $clog2(NumCells);

  localparam logic [7:0] ByteEsc  = 8'h1B;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteCr   = 8'h0D;
  localparam logic [7:0] ByteBs   = 8'h08;
  localparam logic [7:0] ByteSemi = 8'h3B;
  localparam logic [7:0] ByteZero = 8'h30;
  localparam logic [7:0] ByteNine = 8'h39;
  localparam logic [7:0] ByteLbr  = 8'h5B;
  localparam logic [7:0] ByteC    = 8'h63;
  localparam logic [7:0] ByteSpc  = 8'h20;

  localparam logic [7:0] FinA = 8'h41;
  localparam logic [7:0] FinB = 8'h42;
  localparam logic [7:0] FinC = 8'h43;
  localparam logic [7:0] FinD = 8'h44;
  localparam logic [7:0] FinE = 8'h45;
  localparam logic [7:0] FinF = 8'h46;
  localparam logic [7:0] FinG = 8'h47;
  localparam logic [7:0] FinH = 8'h48;
  localparam logic [7:0] FinLf = 8'h66;
  localparam logic [7:0] FinS = 8'h73;
  localparam logic [7:0] FinU = 8'h75;
  localparam logic [7:0] FinM = 8'h6D;

  localparam logic [7:0] SgrFg = 8'd30;
  localparam logic [7:0] SgrBg = 8'd40;

  typedef enum logic [1:0] {
    PmNormal = 2'd0,
    PmEsc    = 2'd1,
    PmCsi    = 2'd2
  } pmode_e;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_in;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
    logic [7:0] attr_out;
    logic       in_sequence;
  } out_t;

  typedef enum logic [3:0] {
    StIdle, StFeed, StRead, StReadWait, StScrRd, StScrWait, StScrWr,
    StZero, StClear, StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic feed;      // apply byte to registers
    logic rd_cell;   // issue read of addressed cell
    logic rd_take;   // latch read data into result
    logic scr_rd;    // scroll: read src = ptr + cols
    logic scr_wr;    // scroll: write ptr
    logic fill;      // write ptr with fill value
    logic ptr_clr;
    logic ptr_inc;
    logic fill_space;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic need_clear;
    logic ptr_row_last; // ptr in last row
    logic ptr_end;      // ptr at last cell
  } sts_t;

  function automatic logic [3:0] color_map(input logic [2:0] i, input logic br);
    logic [2:0] c;
    c = {i[0], i[1], i[2]};
    return {br, c};
  endfunction

endpackage

FILE: rtl/core/ansi_text_terminal_core.sv
// channel | dir | handshake         | beat
// in      | in  | in_valid/in_stall  | att_pkg::in_t
// out     | out | out_valid/out_stall| att_pkg::out_t
// cfg     | in  | cfg_valid/cfg_ready| default_attr, 8 bits
// a read or ordinary byte goes through capture, then register update or cell access, then the result
// newline or wrap on the last row scrolls the cell ram up a row: each of the first 1920 cells
// is read from one row below and written back, then the 80 cells of the last row are zeroed
// ESC c and reset sweep all 2000 cells, one a cycle; input is stalled meanwhile
// the result beat holds until out_stall_i drops
module ansi_text_terminal_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  att_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output att_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_data_i
);
  import att_pkg::*;

  cmd_t cmd;
  sts_t sts;

  att_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  att_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: rtl/core/att_ctrl.sv
module att_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          cfg_ready_o,
  input  att_pkg::sts_t sts_i,
  output att_pkg::cmd_t cmd_o
);
  import att_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StFeed;
        end
      end
      StFeed: begin
        if (sts_i.is_read) begin
          state_d = StRead;
        end else begin
          cmd_o.feed    = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          if (sts_i.need_clear) begin
            state_d = StClear;
          end else if (sts_i.need_scroll) begin
            state_d = StScrRd;
          end else begin
            state_d = StOut;
          end
        end
      end
      StRead: begin
        cmd_o.rd_cell = 1'b1;
        state_d       = StReadWait;
      end
      StReadWait: begin
        cmd_o.rd_take = 1'b1;
        state_d       = StOut;
      end
      StScrRd: begin
        if (sts_i.ptr_row_last) begin
          state_d = StZero;
        end else begin
          cmd_o.scr_rd = 1'b1;
          state_d      = StScrWait;
        end
      end
      StScrWait: state_d = StScrWr;
      StScrWr: begin
        cmd_o.scr_wr  = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = StScrRd;
      end
      StZero: begin
        cmd_o.fill    = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.ptr_end) state_d = StOut;
      end
      StClear: begin
        cmd_o.fill       = 1'b1;
        cmd_o.fill_space = 1'b1;
        cmd_o.ptr_inc    = 1'b1;
        if (sts_i.ptr_end) state_d = sts_i.need_clear ? StOut : StIdle;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

FILE: rtl/core/att_dp.sv
module att_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  att_pkg::in_t  in_data_i,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  input  att_pkg::cmd_t cmd_i,
  output att_pkg::sts_t sts_o,
  output att_pkg::out_t out_data_o
);
  import att_pkg::*;

  logic [15:0] mem [NumCells];
  logic [15:0] rdata_q;

  in_t        item_q;
  logic [7:0] dattr_q;
  logic [RowW-1:0] row_q, row_d, srow_q, srow_d;
  logic [ColW-1:0] col_q, col_d, scol_q, scol_d;
  logic [7:0] attr_q, attr_d;
  logic       bright_q, bright_d;
  pmode_e     pm_q, pm_d;
  logic [7:0] n1_q, n1_d, n2_q, n2_d;
  logic       slot_q, slot_d;
  logic       seen_q, seen_d;
  logic       scroll_q, scroll_d, clear_q, clear_d;
  logic [AddrW-1:0] ptr_q;
  logic [7:0] cch_q, cat_q;

  logic            wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [15:0]     wr_data;
  logic            put_en;
  logic [AddrW-1:0] put_addr;
  logic [15:0]     put_data;

  logic [7:0]  b;
  logic [7:0]  n, m, nm1, mm1, cur;
  logic [8:0]  acc;
  logic [11:0] mul;
  logic [7:0]  sat;
  logic [3:0]  fg, bg;

  function automatic logic [AddrW-1:0] addr_of(input logic [RowW-1:0] r,
                                               input logic [ColW-1:0] c);
    return AddrW'(r * ScreenCols) + AddrW'(c);
  endfunction

  function automatic logic [7:0] sdown(input logic [7:0] v, input logic [7:0] k);
    return (k > v) ? 8'd0 : v - k;
  endfunction

  function automatic logic [7:0] sup(input logic [7:0] v, input logic [7:0] k,
                                     input logic [7:0] mx);
    return (k > mx - v) ? mx : v + k;
  endfunction

  localparam logic [7:0] RowMax = 8'(ScreenRows - 1);
  localparam logic [7:0] ColMax = 8'(ScreenCols - 1);

  always_comb begin
    b        = item_q.byte_in;
    row_d    = row_q;
    col_d    = col_q;
    srow_d   = srow_q;
    scol_d   = scol_q;
    attr_d   = attr_q;
    bright_d = bright_q;
    pm_d     = pm_q;
    n1_d     = n1_q;
    n2_d     = n2_q;
    slot_d   = slot_q;
    seen_d   = seen_q;
    scroll_d = 1'b0;
    clear_d  = 1'b0;
    put_en   = 1'b0;
    put_addr = addr_of(row_q, col_q);
    put_data = {attr_q, b};
    n        = (n1_q == 8'd0) ? 8'd1 : n1_q;
    m        = (slot_q && n2_q != 8'd0) ? n2_q : 8'd1;
    nm1      = n - 8'd1;
    mm1      = m - 8'd1;
    cur      = slot_q ? n2_q : n1_q;
    mul      = {cur, 3'b000} + {3'b000, cur, 1'b0};
    acc      = 9'(mul > 12'd255 ? 12'd255 : mul) + 9'(b - ByteZero);
    sat      = (mul > 12'd255 || acc > 9'd255) ? 8'd255 : acc[7:0];
    fg       = attr_q[3:0];
    bg       = attr_q[7:4];
    if (b == ByteEsc) begin
      pm_d = PmEsc;
    end else if (pm_q == PmEsc) begin
      pm_d = PmNormal;
      if (b == ByteC) begin
        row_d   = '0;
        col_d   = '0;
        attr_d  = dattr_q;
        clear_d = 1'b1;
      end else if (b == ByteLbr) begin
        pm_d   = PmCsi;
        n1_d   = '0;
        n2_d   = '0;
        slot_d = 1'b0;
        seen_d = 1'b0;
      end
    end else if (pm_q == PmCsi) begin
      if (b >= ByteZero && b <= ByteNine) begin
        if (slot_q) n2_d = sat; else n1_d = sat;
        seen_d = 1'b1;
      end else if (b == ByteSemi) begin
        slot_d = 1'b1;
        n2_d   = '0;
      end else begin
        pm_d = PmNormal;
        unique case (b)
          FinA: row_d = RowW'(sdown(8'(row_q), n));
          FinB: row_d = RowW'(sup(8'(row_q), n, RowMax));
          FinC: col_d = ColW'(sup(8'(col_q), n, ColMax));
          FinD: col_d = ColW'(sdown(8'(col_q), n));
          FinE: begin
            row_d = RowW'(sup(8'(row_q), n, RowMax));
            col_d = '0;
          end
          FinF: begin
            row_d = RowW'(sdown(8'(row_q), n));
            col_d = '0;
          end
          FinG: col_d = ColW'(sup(8'd0, nm1, ColMax));
          FinH, FinLf: begin
            row_d = RowW'(sup(8'd0, nm1, RowMax));
            col_d = ColW'(sup(8'd0, mm1, ColMax));
          end
          FinS: begin
            srow_d = row_q;
            scol_d = col_q;
          end
          FinU: begin
            row_d = srow_q;
            col_d = scol_q;
          end
          FinM: begin
            if (n1_q == 8'd0) bright_d = 1'b0;
            else if (n1_q == 8'd1) bright_d = 1'b1;
            else if (n1_q >= SgrFg && n1_q <= SgrFg + 8'd7)
              fg = color_map(3'(n1_q - SgrFg), bright_q);
            else if (n1_q >= SgrBg && n1_q <= SgrBg + 8'd7)
              bg = color_map(3'(n1_q - SgrBg), bright_q);
            attr_d = {bg, fg};
          end
          default: ;
        endcase
      end
    end else begin
      pm_d = PmNormal;
      if (b == ByteLf) begin
        col_d = '0;
        if (8'(row_q) < RowMax) row_d = row_q + 1'b1; else scroll_d = 1'b1;
      end else if (b == ByteCr) begin
        col_d = '0;
      end else if (b == ByteBs) begin
        if (col_q != '0) col_d = col_q - 1'b1;
        put_en   = 1'b1;
        put_addr = addr_of(row_q, col_d);
        put_data = {attr_q, 8'd0};
      end else begin
        put_en = 1'b1;
        if (8'(col_q) == ColMax) begin
          col_d = '0;
          if (8'(row_q) < RowMax) row_d = row_q + 1'b1; else scroll_d = 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q;
    wr_data = cmd_i.fill_space ? {dattr_q, ByteSpc} : 16'd0;
    rd_addr = ptr_q + AddrW'(ScreenCols);
    if (cmd_i.feed && put_en) begin
      wr_en   = 1'b1;
      wr_addr = put_addr;
      wr_data = put_data;
    end else if (cmd_i.scr_wr) begin
      wr_en   = 1'b1;
      wr_data = rdata_q;
    end else if (cmd_i.fill) begin
      wr_en = 1'b1;
    end
    if (cmd_i.rd_cell) rd_addr = addr_of(item_q.read_row, item_q.read_col);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_cell || cmd_i.scr_rd) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dattr_q  <= 8'd7;
      row_q    <= '0;
      col_q    <= '0;
      srow_q   <= '0;
      scol_q   <= '0;
      attr_q   <= 8'd7;
      bright_q <= 1'b0;
      pm_q     <= PmNormal;
      n1_q     <= '0;
      n2_q     <= '0;
      slot_q   <= 1'b0;
      seen_q   <= 1'b0;
      scroll_q <= 1'b0;
      clear_q  <= 1'b0;
      ptr_q    <= '0;
      cch_q    <= '0;
      cat_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        dattr_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        cch_q    <= '0;
        cat_q    <= '0;
        scroll_q <= 1'b0;
        clear_q  <= 1'b0;
      end
      if (cmd_i.feed) begin
        row_q    <= row_d;
        col_q    <= col_d;
        srow_q   <= srow_d;
        scol_q   <= scol_d;
        attr_q   <= attr_d;
        bright_q <= bright_d;
        pm_q     <= pm_d;
        n1_q     <= n1_d;
        n2_q     <= n2_d;
        slot_q   <= slot_d;
        seen_q   <= seen_d;
        scroll_q <= scroll_d;
        clear_q  <= clear_d;
      end
      if (cmd_i.rd_take) begin
        if (item_q.read_row < RowW'(ScreenRows) && item_q.read_col < ColW'(ScreenCols)) begin
          cch_q <= rdata_q[7:0];
          cat_q <= rdata_q[15:8];
        end
      end
      if (cmd_i.ptr_clr) ptr_q <= '0;
      else if (cmd_i.ptr_inc) ptr_q <= sts_o.ptr_end ? '0 : ptr_q + 1'b1;
    end
  end

  assign sts_o.is_read      = item_q.func;
  assign sts_o.need_scroll  = scroll_d;
  assign sts_o.need_clear   = cmd_i.feed ? clear_d : clear_q;
  assign sts_o.ptr_row_last = ptr_q >= AddrW'(NumCells - ScreenCols);
  assign sts_o.ptr_end      = ptr_q == AddrW'(NumCells - 1);

  assign out_data_o.cell_char      = cch_q;
  assign out_data_o.cell_attr      = cat_q;
  assign out_data_o.cursor_row_out = row_q;
  assign out_data_o.cursor_col_out = col_q;
  assign out_data_o.attr_out       = attr_q;
  assign out_data_o.in_sequence    = (pm_q == PmEsc) || (pm_q == PmCsi);

endmodule
